// ===== design/icf_pkg.sv =====
// shared types, codes and helpers of the chunked image framer
// holds payload structs, the queue command format, header and crc functions
// no dependencies
`default_nettype none

package icf_pkg;

  // default sizing
  localparam int CHUNK_BYTES_DEF = 4096;
  localparam int MAX_SIDE_DEF    = 255;
  localparam int QUEUE_DEPTH_DEF = 4;

  // frame format
  localparam int          HDR_LEN     = 22;
  localparam int          CRC_FIRST   = 4;
  localparam int          STEP_W      = 5;
  localparam logic [7:0]  MAGIC_0     = 8'h4D;
  localparam logic [7:0]  MAGIC_1     = 8'h4C;
  localparam logic [7:0]  MAGIC_2     = 8'h58;
  localparam logic [7:0]  MAGIC_3     = 8'h34;
  localparam logic [7:0]  FRAME_VER   = 8'h01;
  localparam logic [7:0]  FRAME_KIND  = 8'h02;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  // input operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_SIZE  = 2'd1;
  localparam logic [1:0] STATUS_IDLE_BYTE = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic [31:0] time_tag;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       chunk_end;
    logic       image_end;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    CMD_SIZE_ERR = 2'd0,
    CMD_IDLE_ERR = 2'd1,
    CMD_START    = 2'd2,
    CMD_DATA     = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0]  side_w;
    logic [7:0]  side_h;
    logic [31:0] sequence_no;
    logic [31:0] stamp;
    logic [15:0] payload_len;
    logic [15:0] part_no;
    logic [15:0] part_total;
  } hdr_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
    logic       chunk_done;
    logic       final_chunk;
    hdr_t       hdr;
  } cmd_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] header_byte(hdr_t h, logic [STEP_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = MAGIC_0;
      5'd1:    b = MAGIC_1;
      5'd2:    b = MAGIC_2;
      5'd3:    b = MAGIC_3;
      5'd4:    b = FRAME_VER;
      5'd5:    b = FRAME_KIND;
      5'd6:    b = h.side_w;
      5'd7:    b = h.side_h;
      5'd8:    b = h.sequence_no[7:0];
      5'd9:    b = h.sequence_no[15:8];
      5'd10:   b = h.sequence_no[23:16];
      5'd11:   b = h.sequence_no[31:24];
      5'd12:   b = h.stamp[7:0];
      5'd13:   b = h.stamp[15:8];
      5'd14:   b = h.stamp[23:16];
      5'd15:   b = h.stamp[31:24];
      5'd16:   b = h.payload_len[7:0];
      5'd17:   b = h.payload_len[15:8];
      5'd18:   b = h.part_no[7:0];
      5'd19:   b = h.part_no[15:8];
      5'd20:   b = h.part_total[7:0];
      5'd21:   b = h.part_total[15:8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== design/icf_front.sv =====
// front end: accepts input beats, checks size, tracks image and chunk position
// pushes one command per item into the queue; depends on icf_pkg
`default_nettype none

module icf_front #(
  parameter int CHUNK_BYTES = icf_pkg::CHUNK_BYTES_DEF,
  parameter int MAX_SIDE    = icf_pkg::MAX_SIDE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire icf_pkg::in_t  in_data,
  input  wire logic [15:0]   cfg_width,
  input  wire logic [15:0]   cfg_height,
  output logic               push_valid,
  input  wire logic          push_ready,
  output icf_pkg::cmd_t      push_cmd
);

  localparam int TOTAL_W    = $clog2(2 * MAX_SIDE * MAX_SIDE + 1);
  localparam int NUM_W      = $clog2(2 * MAX_SIDE * MAX_SIDE + CHUNK_BYTES);
  localparam int MAX_CHUNKS = (2 * MAX_SIDE * MAX_SIDE + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int CHUNK_W    = $clog2(MAX_CHUNKS + 1);
  localparam int SIZE_W     = $clog2(CHUNK_BYTES + 1);
  // reciprocal of the chunk size, exact for every numerator below 2**NUM_W
  localparam int DIV_SH     = NUM_W + $clog2(CHUNK_BYTES);
  localparam int PROD_W     = 2 * NUM_W + 1;
  localparam logic [NUM_W:0] DIV_MUL = (NUM_W+1)'(
    ((longint'(1) << DIV_SH) + longint'(CHUNK_BYTES) - longint'(1)) / longint'(CHUNK_BYTES));

  typedef enum logic {F_RUN, F_DIV} state_t;

  state_t             state_r, state_nxt;
  logic               busy_r, busy_nxt;
  logic [31:0]        seq_r, seq_nxt;
  logic [31:0]        stamp_r, stamp_nxt;
  logic [7:0]         side_w_r, side_w_nxt;
  logic [7:0]         side_h_r, side_h_nxt;
  logic [TOTAL_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [CHUNK_W-1:0] chunk_num_r, chunk_num_nxt;
  logic [CHUNK_W-1:0] chunk_tot_r, chunk_tot_nxt;
  logic [SIZE_W-1:0]  fill_r, fill_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [NUM_W-1:0]   div_num_r, div_num_nxt;

  logic               accept;
  logic               bad_size;
  logic [15:0]        prod;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] bl_dec;
  logic [SIZE_W-1:0]  fill_inc;
  logic               done;
  logic               fin;
  logic [PROD_W-1:0]  quot_full;

  assign in_ready = (state_r == F_RUN) && push_ready;
  assign accept   = in_valid && in_ready;

  assign bad_size = (cfg_width == 16'd0) || (cfg_height == 16'd0) ||
                    (cfg_width > 16'(MAX_SIDE)) || (cfg_height > 16'(MAX_SIDE));
  assign prod     = 16'(cfg_width[7:0]) * 16'(cfg_height[7:0]);
  assign total    = TOTAL_W'({prod, 1'b0});

  assign bl_dec   = bytes_left_r - TOTAL_W'(1);
  assign fill_inc = fill_r + SIZE_W'(1);
  assign done     = fill_inc >= size_r;
  assign fin      = done && (bl_dec == '0);

  // chunk count as a rounded-up quotient, one multiply in the cycle after the start
  assign quot_full = PROD_W'(div_num_r) * PROD_W'(DIV_MUL);

  always_comb begin
    state_nxt      = state_r;
    busy_nxt       = busy_r;
    seq_nxt        = seq_r;
    stamp_nxt      = stamp_r;
    side_w_nxt     = side_w_r;
    side_h_nxt     = side_h_r;
    bytes_left_nxt = bytes_left_r;
    chunk_num_nxt  = chunk_num_r;
    chunk_tot_nxt  = chunk_tot_r;
    fill_nxt       = fill_r;
    size_nxt       = size_r;
    div_num_nxt    = div_num_r;
    push_valid     = 1'b0;
    push_cmd.kind        = icf_pkg::CMD_DATA;
    push_cmd.data_byte   = in_data.data_byte;
    push_cmd.chunk_done  = done;
    push_cmd.final_chunk = fin;

    unique case (state_r)
      F_RUN: begin
        if (accept) begin
          if (in_data.operation == icf_pkg::OP_START) begin
            if (bad_size) begin
              push_valid    = 1'b1;
              push_cmd.kind = icf_pkg::CMD_SIZE_ERR;
            end else begin
              side_w_nxt     = cfg_width[7:0];
              side_h_nxt     = cfg_height[7:0];
              stamp_nxt      = in_data.time_tag;
              busy_nxt       = 1'b1;
              bytes_left_nxt = total;
              chunk_num_nxt  = '0;
              fill_nxt       = '0;
              size_nxt       = (32'(total) > 32'(CHUNK_BYTES)) ? SIZE_W'(CHUNK_BYTES)
                                                               : SIZE_W'(total);
              div_num_nxt    = NUM_W'(total) + NUM_W'(CHUNK_BYTES - 1);
              state_nxt      = F_DIV;
            end
          end else if (!busy_r) begin
            push_valid    = 1'b1;
            push_cmd.kind = icf_pkg::CMD_IDLE_ERR;
          end else begin
            push_valid     = 1'b1;
            push_cmd.kind  = icf_pkg::CMD_DATA;
            bytes_left_nxt = bl_dec;
            fill_nxt       = fill_inc;
            if (fin) begin
              busy_nxt = 1'b0;
              seq_nxt  = seq_r + 32'd1;
              fill_nxt = '0;
              size_nxt = '0;
            end else if (done) begin
              chunk_num_nxt = chunk_num_r + CHUNK_W'(1);
              fill_nxt      = '0;
              size_nxt      = (32'(bl_dec) > 32'(CHUNK_BYTES)) ? SIZE_W'(CHUNK_BYTES)
                                                               : SIZE_W'(bl_dec);
            end
          end
        end
      end
      F_DIV: begin
        chunk_tot_nxt = quot_full[DIV_SH +: CHUNK_W];
        if (push_ready) begin
          push_valid    = 1'b1;
          push_cmd.kind = icf_pkg::CMD_START;
          state_nxt     = F_RUN;
        end
      end
      default: state_nxt = F_RUN;
    endcase

    // header of the chunk that opens next, taken from the updated position
    push_cmd.hdr.side_w      = side_w_nxt;
    push_cmd.hdr.side_h      = side_h_nxt;
    push_cmd.hdr.sequence_no = seq_nxt;
    push_cmd.hdr.stamp       = stamp_nxt;
    push_cmd.hdr.payload_len = 16'(size_nxt);
    push_cmd.hdr.part_no     = 16'(chunk_num_nxt);
    push_cmd.hdr.part_total  = 16'(chunk_tot_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_RUN;
      busy_r       <= 1'b0;
      seq_r        <= '0;
      stamp_r      <= '0;
      side_w_r     <= '0;
      side_h_r     <= '0;
      bytes_left_r <= '0;
      chunk_num_r  <= '0;
      chunk_tot_r  <= '0;
      fill_r       <= '0;
      size_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      busy_r       <= busy_nxt;
      seq_r        <= seq_nxt;
      stamp_r      <= stamp_nxt;
      side_w_r     <= side_w_nxt;
      side_h_r     <= side_h_nxt;
      bytes_left_r <= bytes_left_nxt;
      chunk_num_r  <= chunk_num_nxt;
      chunk_tot_r  <= chunk_tot_nxt;
      fill_r       <= fill_nxt;
      size_r       <= size_nxt;
    end
    div_num_r <= div_num_nxt;
  end

endmodule

`default_nettype wire

// ===== design/icf_queue.sv =====
// command queue between front and back end
// small register fifo of icf_pkg::cmd_t entries; depends on icf_pkg
`default_nettype none

module icf_queue #(
  parameter int DEPTH = icf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire icf_pkg::cmd_t  push_cmd,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output icf_pkg::cmd_t       pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  icf_pkg::cmd_t    entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== design/icf_back.sv =====
// back end: expands queued commands into output beats and runs the crc
// owns the output register; depends on icf_pkg
`default_nettype none

module icf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire icf_pkg::cmd_t  pop_cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output icf_pkg::out_t       out_data
);

  localparam int SW            = icf_pkg::STEP_W;
  localparam logic [SW-1:0] STEP_CRC_LO  = SW'(1);
  localparam logic [SW-1:0] STEP_CRC_HI  = SW'(2);
  localparam logic [SW-1:0] STEP_HDR_OFS = SW'(3);
  localparam logic [SW-1:0] HDR_LAST     = SW'(icf_pkg::HDR_LEN - 1);

  logic [SW-1:0]  step_r;
  logic [15:0]    crc_r;
  logic           out_valid_r;
  icf_pkg::out_t  out_data_r;

  logic           emit;
  logic           beat_last;
  logic           hdr_beat;
  logic [SW-1:0]  hdr_idx;
  logic [7:0]     hdr_b;
  logic [15:0]    crc_nxt;
  icf_pkg::out_t  beat;

  assign emit      = pop_valid && (!out_valid_r || out_ready);
  assign pop_ready = emit && beat_last;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign hdr_idx = (pop_cmd.kind == icf_pkg::CMD_START) ? step_r : step_r - STEP_HDR_OFS;
  assign hdr_b   = icf_pkg::header_byte(pop_cmd.hdr, hdr_idx);

  always_comb begin
    beat            = '0;
    beat.status     = icf_pkg::STATUS_OK;
    beat_last       = 1'b0;
    hdr_beat        = 1'b0;
    crc_nxt         = crc_r;
    unique case (pop_cmd.kind)
      icf_pkg::CMD_SIZE_ERR: begin
        beat.status = icf_pkg::STATUS_BAD_SIZE;
        beat_last   = 1'b1;
      end
      icf_pkg::CMD_IDLE_ERR: begin
        beat.status = icf_pkg::STATUS_IDLE_BYTE;
        beat_last   = 1'b1;
      end
      icf_pkg::CMD_START: begin
        hdr_beat  = 1'b1;
        beat_last = step_r == HDR_LAST;
      end
      icf_pkg::CMD_DATA: begin
        priority if (step_r == '0) begin
          beat.out_byte   = pop_cmd.data_byte;
          beat.byte_valid = 1'b1;
          beat_last       = !pop_cmd.chunk_done;
          crc_nxt         = icf_pkg::crc16_byte(crc_r, pop_cmd.data_byte);
        end else if (step_r == STEP_CRC_LO) begin
          beat.out_byte   = crc_r[7:0];
          beat.byte_valid = 1'b1;
        end else if (step_r == STEP_CRC_HI) begin
          beat.out_byte   = crc_r[15:8];
          beat.byte_valid = 1'b1;
          beat.chunk_end  = 1'b1;
          beat.image_end  = pop_cmd.final_chunk;
          beat_last       = pop_cmd.final_chunk;
        end else begin
          hdr_beat  = 1'b1;
          beat_last = hdr_idx == HDR_LAST;
        end
      end
      default: beat_last = 1'b1;
    endcase
    if (hdr_beat) begin
      beat.out_byte   = hdr_b;
      beat.byte_valid = 1'b1;
      // magic bytes restart the checksum, the rest of the header feeds it
      crc_nxt = (hdr_idx < SW'(icf_pkg::CRC_FIRST)) ? icf_pkg::CRC_INIT
                                                    : icf_pkg::crc16_byte(crc_r, hdr_b);
    end
    beat.last = beat_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      crc_r       <= icf_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        step_r      <= beat_last ? '0 : step_r + SW'(1);
        crc_r       <= crc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (emit) begin
      out_data_r <= beat;
    end
  end

endmodule

`default_nettype wire

// ===== design/image_chunk_framer_crc16_core.sv =====
// top level of the chunked rgb565 framer with crc-16/ccitt-false
// holds the size registers and ties front end, command queue and back end
// depends on icf_pkg, icf_front, icf_queue, icf_back
// a data beat is taken every cycle while the queue has room; a start holds the input
// while the chunk count comes out of a reciprocal multiply and the start is queued
// result beats leave the output register one per cycle while the result side is ready;
// a chunk's last data beat adds the crc bytes and, unless the image ends, the next header
// reset (synchronous, active low) clears control state, counters and crc; no clearing pass
`default_nettype none

module image_chunk_framer_crc16_core #(
  parameter int CHUNK_BYTES = icf_pkg::CHUNK_BYTES_DEF,
  parameter int MAX_SIDE    = icf_pkg::MAX_SIDE_DEF,
  parameter int QUEUE_DEPTH = icf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input beats
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire icf_pkg::in_t                  in_data,
  // result beats
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output icf_pkg::out_t                      out_data,
  // register writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [icf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);

  // size registers, written over the register port; the front end latches them on a valid start
  logic [15:0] width_r;
  logic [15:0] height_r;

  // front to queue
  logic          q_push_valid;
  logic          q_push_ready;
  icf_pkg::cmd_t q_push_cmd;
  // queue to back
  logic          q_pop_valid;
  logic          q_pop_ready;
  icf_pkg::cmd_t q_pop_cmd;

  // writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_valid) begin
      unique case (icf_pkg::cfg_idx_t'(cfg_index))
        icf_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        icf_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data;
      endcase
    end
  end

  // front end: size check, image and chunk bookkeeping, chunk count
  icf_front #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .MAX_SIDE    (MAX_SIDE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd)
  );

  // short queue so a stalled link does not stop the front at once
  icf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_cmd    (q_pop_cmd)
  );

  // back end: header, payload and crc beats into the output register
  icf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_cmd   (q_pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // no result beat straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // the front never offers a command the queue cannot take
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push_valid |-> q_push_ready)
    else $error("command pushed into a full queue");

  // retiring a command always loads its final beat into the output register
  a_pop_loads_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop_valid && q_pop_ready) |=> (out_valid && out_data.last))
    else $error("command retired without its final beat");

endmodule

`default_nettype wire

// ===== sim/tb_image_chunk_framer_crc16_core.sv =====
// self-checking bench for image_chunk_framer_crc16_core: chunk headers, payload and crc-16
// an in-bench scoreboard predicts every result beat; random idling on the input and result channels
// depends on icf_pkg and the design sources
`timescale 1ns / 1ps

module tb_image_chunk_framer_crc16_core;
  import icf_pkg::*;

  // predicts the framed byte stream and checks the result beats against it
  class chunk_frame_scoreboard;
    logic [15:0] width_reg, height_reg;
    bit          busy;
    bit   [7:0]  side_w, side_h;
    bit  [31:0]  img_seq, stamp;
    bit  [16:0]  bytes_left;
    bit   [5:0]  chunk_no, chunk_cnt;
    bit  [12:0]  fill, chunk_len;
    bit  [15:0]  crc;
    out_t        burst[$];
    out_t        frame_beats_due[$];
    int          failures;

    function new();
      width_reg  = '0;
      height_reg = '0;
      crc        = CRC_INIT;
    endfunction

    // bit-serial crc-16, msb first, no reflection
    function bit [15:0] crc_feed(bit [15:0] c, bit [7:0] b);
      for (int i = 7; i >= 0; i--) begin
        if (c[15] ^ b[i]) c = {c[14:0], 1'b0} ^ CRC_POLY;
        else c = {c[14:0], 1'b0};
      end
      return c;
    endfunction

    function void add_beat(bit [7:0] b, bit v, logic [1:0] st, bit ce, bit ie);
      out_t r;
      r.out_byte   = v ? b : 8'h00;
      r.byte_valid = v;
      r.status     = st;
      r.chunk_end  = ce;
      r.image_end  = ie;
      r.last       = 1'b0;
      burst.push_back(r);
    endfunction

    function void open_chunk();
      chunk_len = (bytes_left > CHUNK_BYTES_DEF) ? 13'(CHUNK_BYTES_DEF) : 13'(bytes_left);
      fill      = '0;
      crc       = CRC_INIT;
    endfunction

    function void send_header();
      bit [7:0]  hb [HDR_LEN];
      bit [15:0] len16, idx16, cnt16;
      len16 = 16'(chunk_len);
      idx16 = 16'(chunk_no);
      cnt16 = 16'(chunk_cnt);
      hb = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, FRAME_VER, FRAME_KIND, side_w, side_h,
             img_seq[7:0], img_seq[15:8], img_seq[23:16], img_seq[31:24],
             stamp[7:0], stamp[15:8], stamp[23:16], stamp[31:24],
             len16[7:0], len16[15:8], idx16[7:0], idx16[15:8], cnt16[7:0], cnt16[15:8]};
      foreach (hb[i]) begin
        if (i >= CRC_FIRST) crc = crc_feed(crc, hb[i]);
        add_beat(hb[i], 1'b1, STATUS_OK, 1'b0, 1'b0);
      end
    endfunction

    function void take_register(cfg_idx_t idx, logic [15:0] val);
      if (idx == CFG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function void take_input_beat(in_t item);
      bit [16:0] total;
      bit        done;
      burst.delete();
      if (item.operation == OP_START) begin
        if (width_reg == 0 || height_reg == 0 ||
            width_reg > MAX_SIDE_DEF || height_reg > MAX_SIDE_DEF) begin
          add_beat(8'h00, 1'b0, STATUS_BAD_SIZE, 1'b0, 1'b0);
        end else begin
          side_w     = width_reg[7:0];
          side_h     = height_reg[7:0];
          total      = 17'(width_reg * height_reg * 2);
          bytes_left = total;
          chunk_cnt  = 6'((int'(total) + CHUNK_BYTES_DEF - 1) / CHUNK_BYTES_DEF);
          chunk_no   = '0;
          stamp      = item.time_tag;
          busy       = 1'b1;
          open_chunk();
          send_header();
        end
      end else if (!busy) begin
        add_beat(8'h00, 1'b0, STATUS_IDLE_BYTE, 1'b0, 1'b0);
      end else begin
        crc = crc_feed(crc, item.data_byte);
        add_beat(item.data_byte, 1'b1, STATUS_OK, 1'b0, 1'b0);
        fill++;
        bytes_left--;
        if (fill >= chunk_len) begin
          done = (bytes_left == 0);
          add_beat(crc[7:0], 1'b1, STATUS_OK, 1'b0, 1'b0);
          add_beat(crc[15:8], 1'b1, STATUS_OK, 1'b1, done);
          if (done) begin
            busy = 1'b0;
            img_seq++;
            fill      = '0;
            chunk_len = '0;
          end else begin
            chunk_no++;
            open_chunk();
            send_header();
          end
        end
      end
      burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) frame_beats_due.push_back(burst[i]);
    endfunction

    function void flag(string what, out_t want, out_t got);
      failures++;
      if (failures <= 10)
        $display("%s: want byte %02h v %0b st %0d ce %0b ie %0b last %0b,", what,
                 want.out_byte, want.byte_valid, want.status, want.chunk_end,
                 want.image_end, want.last,
                 " got byte %02h v %0b st %0d ce %0b ie %0b last %0b",
                 got.out_byte, got.byte_valid, got.status,
                 got.chunk_end, got.image_end, got.last);
    endfunction

    function void check_output_beat(out_t got);
      out_t want;
      if (frame_beats_due.size() == 0) begin
        flag("result beat with nothing due", '0, got);
        return;
      end
      want = frame_beats_due.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.status !== want.status || got.chunk_end !== want.chunk_end ||
          got.image_end !== want.image_end || got.last !== want.last)
        flag("result beat mismatch", want, got);
    endfunction

    function int pending();
      return frame_beats_due.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [15:0]          cfg_data  = '0;

  chunk_frame_scoreboard sb = new();

  // per-phase idling switches: quiet means back-to-back beats on that side
  bit in_quiet  = 1'b0;
  bit out_quiet = 1'b0;
  int items_sent = 0;

  image_chunk_framer_crc16_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int idle_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  // roughly one phase in four runs with no idling on a given side
  task automatic pick_idling();
    in_quiet  = ($urandom_range(0, 3) == 0);
    out_quiet = ($urandom_range(0, 3) == 0);
  endtask

  // one input beat; valid stays high afterwards so a zero gap keeps it
  // asserted without a drop in between
  task automatic push_item(input logic op, input logic [7:0] b, input logic [31:0] ts);
    int  gap;
    in_t item;
    item.operation = op;
    item.data_byte = b;
    item.time_tag  = ts;
    gap = idle_gap(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.take_input_beat(item);
    items_sent++;
  endtask

  // start beat: data byte field is don't-care, so randomise it for bit toggling
  task automatic start_image(input logic [31:0] ts);
    push_item(OP_START, 8'($urandom_range(0, 255)), ts);
  endtask

  task automatic feed_byte(input logic [7:0] b);
    push_item(OP_DATA, b, $urandom);
  endtask

  task automatic stream_bytes(input int n);
    repeat (n) feed_byte(8'($urandom_range(0, 255)));
  endtask

  // drop valid, let every predicted beat arrive, then wait idle
  // before the block counts as quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // both size registers in one burst, valid held across the pair
  task automatic write_size(input logic [15:0] w, input logic [15:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.take_register(CFG_IMAGE_WIDTH, w);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.take_register(CFG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall per beat, every accepted beat goes to the scoreboard
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_gap(out_quiet);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_output_beat(out_data);
    end
  end

  initial begin : stimulus
    logic [15:0] w, h, t;
    int          total, n, shape;
    bit          ok;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size registers still zero after reset: bad size, then a stray byte
    start_image($urandom);
    feed_byte(8'hA5);

    // each side out of range in turn, including the all-ones register value
    settle();
    write_size(16'd256, 16'd1);
    start_image($urandom);
    settle();
    write_size(16'd1, 16'hFFFF);
    start_image($urandom);
    settle();
    write_size(16'hFFFF, 16'd0);
    start_image($urandom);

    // smallest image, extreme timestamp and byte values, then a byte after the end
    settle();
    write_size(16'd1, 16'd1);
    start_image(32'hFFFF_FFFF);
    feed_byte(8'h00);
    feed_byte(8'hFF);
    feed_byte(8'h3C);

    // largest image: header carries the full chunk length and 32 chunks
    settle();
    write_size(16'd255, 16'd255);
    start_image(32'h0000_0000);
    stream_bytes(3);

    // bad size mid-image leaves the image running
    settle();
    write_size(16'd0, 16'd7);
    start_image($urandom);
    stream_bytes(2);

    // restart while busy drops the unfinished image without its crc
    settle();
    write_size(16'd2, 16'd2);
    start_image(32'h8000_0001);
    stream_bytes(8);

    // random phases of small images, mostly well formed
    while (items_sent < 200) begin
      settle();
      pick_idling();
      if ($urandom_range(0, 9) == 0) begin
        w = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom_range(256, 65535));
        h = 16'($urandom_range(1, 6));
        if ($urandom_range(0, 1) != 0) begin
          t = w;
          w = h;
          h = t;
        end
      end else begin
        w = 16'($urandom_range(1, 4));
        h = 16'($urandom_range(1, 4));
      end
      write_size(w, h);
      ok    = (w != 0 && h != 0 && w <= MAX_SIDE_DEF && h <= MAX_SIDE_DEF);
      total = 2 * w * h;
      n     = ok ? total : 3;
      shape = $urandom_range(0, 9);
      if (shape <= 6) begin
        start_image($urandom);
        stream_bytes(n);
      end else if (shape == 7) begin
        // cut short, then a fresh start over it
        start_image($urandom);
        stream_bytes($urandom_range(0, n - 1));
        start_image($urandom);
        stream_bytes(n);
      end else if (shape == 8) begin
        // overrun: the trailing bytes land on an idle block
        start_image($urandom);
        stream_bytes(n + $urandom_range(1, 3));
      end else begin
        repeat ($urandom_range(1, 4))
          push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom);
      end
    end

    settle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_image_chunk_framer_crc16_core passed");
    end else begin
      $display("tb_image_chunk_framer_crc16_core failed");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #3_000_000;
    $display("tb_image_chunk_framer_crc16_core failed");
    $finish;
  end

endmodule
